@@ hdl/plcp_pkg.sv @@
// ----------------------------------------------------------------------------
// plcp_pkg: shared types and constants of the plotter command line parser
// Holds the parse phases, command kinds, result actions, the byte codes the
// parser looks for and the per-byte event record passed between modules.
// ----------------------------------------------------------------------------
package plcp_pkg;

   localparam int SCALE_BITS  = 6;
   localparam int TARGET_BITS = 22;
   localparam int FIELD_BITS  = 16;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = 6'd50;

   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_VT    = 8'd11;
   localparam logic [7:0] CH_FF    = 8'd12;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_I     = 8'h49;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_U     = 8'h55;

   typedef enum logic [2:0] {
      PH_FIRST  = 3'd0,
      PH_SECOND = 3'd1,
      PH_THIRD  = 3'd2,
      PH_SKIP   = 3'd3,
      PH_XFIELD = 3'd4,
      PH_YFIELD = 3'd5,
      PH_DONE   = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      CMD_NONE = 3'd0,
      CMD_IN   = 3'd1,
      CMD_SP   = 3'd2,
      CMD_PU   = 3'd3,
      CMD_PD   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_MOVE = 2'd1,
      ACT_DRAW = 2'd2,
      ACT_HOME = 2'd3
   } action_type;

   // What one consumed byte does to the counters and the result side.
   typedef struct packed {
      logic       line_end;
      logic       point;
      action_type action;
      logic       bump_pu;
      logic       bump_pd;
      logic       bump_sp;
   } event_type;

endpackage

@@ hdl/plcp_parse.sv @@
// ----------------------------------------------------------------------------
// plcp_parse: per-line command parser
// Keeps the state of the line being read and turns each consumed byte into
// an event record; at a newline it also presents the parsed point.
// ----------------------------------------------------------------------------
module plcp_parse #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [7:0]                    char_in,
   output plcp_pkg::event_type           ev,
   output logic signed [COORD_BITS-1:0]  point_x,
   output logic signed [COORD_BITS-1:0]  point_y
);
   import plcp_pkg::*;

   localparam logic [COORD_BITS-1:0] MAG_LIMIT = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic [COORD_BITS-1:0] POS_MAX   = {1'b0, {(COORD_BITS-1){1'b1}}};

   phase_type             phase_ff, phase_in;
   kind_type              kind_ff, kind_in;
   logic [7:0]            first_ff, first_in;
   logic [COORD_BITS-1:0] xmag_ff, xmag_in;
   logic [COORD_BITS-1:0] ymag_ff, ymag_in;
   logic                  xneg_ff, xneg_in;
   logic                  xstop_ff, xstop_in;
   logic                  yneg_ff, yneg_in;
   logic                  ystop_ff, ystop_in;
   logic                  ybegun_ff, ybegun_in;
   logic                  complete_ff, complete_in;
   logic                  sp0_ff, sp0_in;

   logic       is_digit;
   logic       skip_now;
   action_type line_action;

   // Decimal accumulate with saturation at the magnitude limit.
   function automatic logic [COORD_BITS-1:0] accum(input logic [COORD_BITS-1:0] mag,
                                                   input logic [3:0] digit);
      logic [COORD_BITS+3:0] wide;
      logic [COORD_BITS-1:0] res;
      wide = ({4'b0, mag} << 3) + ({4'b0, mag} << 1) + {{COORD_BITS{1'b0}}, digit};
      if (wide > {4'b0, MAG_LIMIT}) begin
         res = MAG_LIMIT;
      end else begin
         res = wide[COORD_BITS-1:0];
      end
      return res;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] signed_val(
      input logic [COORD_BITS-1:0] mag, input logic neg);
      logic [COORD_BITS-1:0] res;
      if (neg) begin
         res = ~mag + 1'b1;
      end else if (mag > POS_MAX) begin
         res = POS_MAX;
      end else begin
         res = mag;
      end
      return $signed(res);
   endfunction

   assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
   assign skip_now = (phase_ff == PH_SKIP) || ((phase_ff == PH_THIRD) && (kind_ff != CMD_SP));

   assign point_x = signed_val(xmag_ff, xneg_ff);
   assign point_y = signed_val(ymag_ff, yneg_ff);

   always_comb begin
      priority if (((kind_ff == CMD_PU) || (kind_ff == CMD_PD)) && complete_ff) begin
         line_action = (kind_ff == CMD_PU) ? ACT_MOVE : ACT_DRAW;
      end else if ((kind_ff == CMD_SP) && sp0_ff) begin
         line_action = ACT_HOME;
      end else begin
         line_action = ACT_NONE;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      kind_in     = kind_ff;
      first_in    = first_ff;
      xmag_in     = xmag_ff;
      ymag_in     = ymag_ff;
      xneg_in     = xneg_ff;
      xstop_in    = xstop_ff;
      yneg_in     = yneg_ff;
      ystop_in    = ystop_ff;
      ybegun_in   = ybegun_ff;
      complete_in = complete_ff;
      sp0_in      = sp0_ff;
      ev          = '0;
      ev.action   = ACT_NONE;

      priority if (char_in == CH_CR) begin
         // Carriage return is dropped everywhere.
      end else if (char_in == CH_LF) begin
         ev.line_end = 1'b1;
         ev.action   = line_action;
         ev.point    = (line_action == ACT_MOVE) || (line_action == ACT_DRAW);
         phase_in    = PH_FIRST;
         kind_in     = CMD_NONE;
         first_in    = '0;
         xmag_in     = '0;
         ymag_in     = '0;
         xneg_in     = 1'b0;
         xstop_in    = 1'b0;
         yneg_in     = 1'b0;
         ystop_in    = 1'b0;
         ybegun_in   = 1'b0;
         complete_in = 1'b0;
         sp0_in      = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_FIRST: begin
               first_in = char_in;
               phase_in = PH_SECOND;
            end
            PH_SECOND: begin
               priority if ((first_ff == CH_I) && (char_in == CH_N)) begin
                  kind_in  = CMD_IN;
                  phase_in = PH_DONE;
               end else if ((first_ff == CH_S) && (char_in == CH_P)) begin
                  kind_in    = CMD_SP;
                  ev.bump_sp = 1'b1;
                  phase_in   = PH_THIRD;
               end else if ((first_ff == CH_P) && (char_in == CH_U)) begin
                  kind_in    = CMD_PU;
                  ev.bump_pu = 1'b1;
                  phase_in   = PH_THIRD;
               end else if ((first_ff == CH_P) && (char_in == CH_D)) begin
                  kind_in    = CMD_PD;
                  ev.bump_pd = 1'b1;
                  phase_in   = PH_THIRD;
               end else begin
                  kind_in  = CMD_NONE;
                  phase_in = PH_DONE;
               end
            end
            PH_THIRD: begin
               if (kind_ff == CMD_SP) begin
                  sp0_in   = (char_in == CH_ZERO);
                  phase_in = PH_DONE;
               end
            end
            PH_SKIP: begin
            end
            PH_XFIELD: begin
               if ((char_in == CH_SPACE) || (char_in == CH_COMMA)) begin
                  phase_in = PH_YFIELD;
               end else if (!xstop_ff) begin
                  if (is_digit) begin
                     xmag_in = accum(xmag_ff, char_in[3:0]);
                  end else begin
                     xstop_in = 1'b1;
                  end
               end
            end
            PH_YFIELD: begin
               priority if (char_in == CH_SEMI) begin
                  complete_in = 1'b1;
                  phase_in    = PH_DONE;
               end else if (ystop_ff) begin
                  // The rest of the Y field is ignored.
               end else if (is_digit) begin
                  ymag_in   = accum(ymag_ff, char_in[3:0]);
                  ybegun_in = 1'b1;
               end else if (!ybegun_ff && ((char_in == CH_SPACE) || (char_in == CH_TAB) ||
                                           (char_in == CH_VT) || (char_in == CH_FF))) begin
                  // Leading white space before Y.
               end else if (!ybegun_ff && ((char_in == CH_MINUS) || (char_in == CH_PLUS))) begin
                  yneg_in   = (char_in == CH_MINUS);
                  ybegun_in = 1'b1;
               end else begin
                  ystop_in  = 1'b1;
                  ybegun_in = 1'b1;
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase

         // Skipping ahead to X; the third byte of PU or PD may already start it.
         if (skip_now) begin
            phase_in = PH_SKIP;
            priority if (char_in == CH_SEMI) begin
               phase_in = PH_DONE;
            end else if (char_in == CH_MINUS) begin
               xneg_in  = 1'b1;
               phase_in = PH_XFIELD;
            end else if (is_digit) begin
               xmag_in  = accum(xmag_ff, char_in[3:0]);
               phase_in = PH_XFIELD;
            end else begin
               phase_in = PH_SKIP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FIRST;
         kind_ff     <= CMD_NONE;
         first_ff    <= '0;
         xmag_ff     <= '0;
         ymag_ff     <= '0;
         xneg_ff     <= 1'b0;
         xstop_ff    <= 1'b0;
         yneg_ff     <= 1'b0;
         ystop_ff    <= 1'b0;
         ybegun_ff   <= 1'b0;
         complete_ff <= 1'b0;
         sp0_ff      <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         kind_ff     <= kind_in;
         first_ff    <= first_in;
         xmag_ff     <= xmag_in;
         ymag_ff     <= ymag_in;
         xneg_ff     <= xneg_in;
         xstop_ff    <= xstop_in;
         yneg_ff     <= yneg_in;
         ystop_ff    <= ystop_in;
         ybegun_ff   <= ybegun_in;
         complete_ff <= complete_in;
         sp0_ff      <= sp0_in;
      end
   end

endmodule

@@ hdl/plcp_result.sv @@
// ----------------------------------------------------------------------------
// plcp_result: counters, bounding box and result register
// Applies parser events to the saturating counters and the box, scales the
// point and loads the result register at each line end.
// ----------------------------------------------------------------------------
module plcp_result #(
   parameter int COORD_BITS = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   step,
   input  plcp_pkg::event_type                    ev,
   input  logic signed [COORD_BITS-1:0]           point_x,
   input  logic signed [COORD_BITS-1:0]           point_y,
   input  logic [plcp_pkg::SCALE_BITS-1:0]        scale,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic [1:0]                             rsp_action,
   output logic signed [plcp_pkg::TARGET_BITS-1:0] rsp_target_x,
   output logic signed [plcp_pkg::TARGET_BITS-1:0] rsp_target_y,
   output logic signed [plcp_pkg::FIELD_BITS-1:0] rsp_box_min_x,
   output logic signed [plcp_pkg::FIELD_BITS-1:0] rsp_box_max_x,
   output logic signed [plcp_pkg::FIELD_BITS-1:0] rsp_box_min_y,
   output logic signed [plcp_pkg::FIELD_BITS-1:0] rsp_box_max_y,
   output logic                                   rsp_box_valid,
   output logic [plcp_pkg::FIELD_BITS-1:0]        rsp_pen_up_count,
   output logic [plcp_pkg::FIELD_BITS-1:0]        rsp_pen_down_count,
   output logic [plcp_pkg::FIELD_BITS-1:0]        rsp_pen_select_count,
   output logic [plcp_pkg::FIELD_BITS-1:0]        rsp_line_count
);
   import plcp_pkg::*;

   localparam int PROD_BITS = COORD_BITS + SCALE_BITS + 1;

   logic [COUNT_BITS-1:0] pu_ff, pu_in;
   logic [COUNT_BITS-1:0] pd_ff, pd_in;
   logic [COUNT_BITS-1:0] sp_ff, sp_in;
   logic [COUNT_BITS-1:0] lines_ff, lines_in;

   logic signed [COORD_BITS-1:0] min_x_ff, min_x_in;
   logic signed [COORD_BITS-1:0] max_x_ff, max_x_in;
   logic signed [COORD_BITS-1:0] min_y_ff, min_y_in;
   logic signed [COORD_BITS-1:0] max_y_ff, max_y_in;
   logic                         seen_ff, seen_in;

   logic                         valid_ff, valid_in;
   logic                         line_step;
   logic signed [PROD_BITS-1:0]  prod_x, prod_y;
   logic [PROD_BITS+TARGET_BITS-1:0] ext_x, ext_y;
   logic signed [PROD_BITS-1:0]  scale_s;

   logic [1:0]                   act_ff;
   logic [TARGET_BITS-1:0]       tx_ff, ty_ff;
   logic signed [COORD_BITS-1:0] bminx_ff, bmaxx_ff, bminy_ff, bmaxy_ff;
   logic                         bval_ff;
   logic [COUNT_BITS-1:0]        opu_ff, opd_ff, osp_ff, olines_ff;

   logic [COUNT_BITS+FIELD_BITS-1:0] cnt_ext_pu, cnt_ext_pd, cnt_ext_sp, cnt_ext_lines;
   logic [COORD_BITS+FIELD_BITS-1:0] box_ext_0, box_ext_1, box_ext_2, box_ext_3;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c,
                                                     input logic en);
      logic [COUNT_BITS-1:0] res;
      res = c;
      if (en && (c != {COUNT_BITS{1'b1}})) begin
         res = c + 1'b1;
      end
      return res;
   endfunction

   assign line_step = step && ev.line_end;

   always_comb begin
      pu_in    = sat_inc(pu_ff, step && ev.bump_pu);
      pd_in    = sat_inc(pd_ff, step && ev.bump_pd);
      sp_in    = sat_inc(sp_ff, step && ev.bump_sp);
      lines_in = sat_inc(lines_ff, line_step);

      min_x_in = min_x_ff;
      max_x_in = max_x_ff;
      min_y_in = min_y_ff;
      max_y_in = max_y_ff;
      seen_in  = seen_ff;
      if (line_step && ev.point) begin
         seen_in  = 1'b1;
         min_x_in = (!seen_ff || (point_x < min_x_ff)) ? point_x : min_x_ff;
         max_x_in = (!seen_ff || (point_x > max_x_ff)) ? point_x : max_x_ff;
         min_y_in = (!seen_ff || (point_y < min_y_ff)) ? point_y : min_y_ff;
         max_y_in = (!seen_ff || (point_y > max_y_ff)) ? point_y : max_y_ff;
      end

      valid_in = valid_ff && !rsp_ready;
      if (line_step) begin
         valid_in = 1'b1;
      end
   end

   // Scaled targets; zero unless the line carries a point.
   assign scale_s = $signed({{(PROD_BITS-SCALE_BITS){1'b0}}, scale});
   assign prod_x  = ev.point ?
                    $signed({{(PROD_BITS-COORD_BITS){point_x[COORD_BITS-1]}}, point_x}) * scale_s
                    : '0;
   assign prod_y  = ev.point ?
                    $signed({{(PROD_BITS-COORD_BITS){point_y[COORD_BITS-1]}}, point_y}) * scale_s
                    : '0;
   assign ext_x   = {{TARGET_BITS{prod_x[PROD_BITS-1]}}, prod_x};
   assign ext_y   = {{TARGET_BITS{prod_y[PROD_BITS-1]}}, prod_y};

   always_ff @(posedge clock) begin
      if (reset) begin
         pu_ff    <= '0;
         pd_ff    <= '0;
         sp_ff    <= '0;
         lines_ff <= '0;
         min_x_ff <= '0;
         max_x_ff <= '0;
         min_y_ff <= '0;
         max_y_ff <= '0;
         seen_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pu_ff    <= pu_in;
         pd_ff    <= pd_in;
         sp_ff    <= sp_in;
         lines_ff <= lines_in;
         min_x_ff <= min_x_in;
         max_x_ff <= max_x_in;
         min_y_ff <= min_y_in;
         max_y_ff <= max_y_in;
         seen_ff  <= seen_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (line_step) begin
         act_ff    <= ev.action;
         tx_ff     <= ext_x[TARGET_BITS-1:0];
         ty_ff     <= ext_y[TARGET_BITS-1:0];
         bminx_ff  <= min_x_in;
         bmaxx_ff  <= max_x_in;
         bminy_ff  <= min_y_in;
         bmaxy_ff  <= max_y_in;
         bval_ff   <= seen_in;
         opu_ff    <= pu_in;
         opd_ff    <= pd_in;
         osp_ff    <= sp_in;
         olines_ff <= lines_in;
      end
   end

   assign cnt_ext_pu    = {{FIELD_BITS{1'b0}}, opu_ff};
   assign cnt_ext_pd    = {{FIELD_BITS{1'b0}}, opd_ff};
   assign cnt_ext_sp    = {{FIELD_BITS{1'b0}}, osp_ff};
   assign cnt_ext_lines = {{FIELD_BITS{1'b0}}, olines_ff};
   assign box_ext_0     = {{FIELD_BITS{bminx_ff[COORD_BITS-1]}}, bminx_ff};
   assign box_ext_1     = {{FIELD_BITS{bmaxx_ff[COORD_BITS-1]}}, bmaxx_ff};
   assign box_ext_2     = {{FIELD_BITS{bminy_ff[COORD_BITS-1]}}, bminy_ff};
   assign box_ext_3     = {{FIELD_BITS{bmaxy_ff[COORD_BITS-1]}}, bmaxy_ff};

   assign rsp_valid            = valid_ff;
   assign rsp_action           = act_ff;
   assign rsp_target_x         = $signed(tx_ff);
   assign rsp_target_y         = $signed(ty_ff);
   assign rsp_box_min_x        = $signed(box_ext_0[FIELD_BITS-1:0]);
   assign rsp_box_max_x        = $signed(box_ext_1[FIELD_BITS-1:0]);
   assign rsp_box_min_y        = $signed(box_ext_2[FIELD_BITS-1:0]);
   assign rsp_box_max_y        = $signed(box_ext_3[FIELD_BITS-1:0]);
   assign rsp_box_valid        = bval_ff;
   assign rsp_pen_up_count     = cnt_ext_pu[FIELD_BITS-1:0];
   assign rsp_pen_down_count   = cnt_ext_pd[FIELD_BITS-1:0];
   assign rsp_pen_select_count = cnt_ext_sp[FIELD_BITS-1:0];
   assign rsp_line_count       = cnt_ext_lines[FIELD_BITS-1:0];

endmodule

@@ hdl/plotter_command_line_parser.sv @@
// ----------------------------------------------------------------------------
// plotter_command_line_parser: plotter command text parser
// Reads command text one byte per beat, handles IN, SP, PU and PD lines and
// gives one result beat per newline with counters and a bounding box.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Payload            | Beat
//   req_    | in        | char_in            | one text byte
//   rsp_    | out       | action ... counts  | one result per newline
//   csr_    | in        | coord_scale        | one register write
//
// Each byte is held in an input register and consumed from it through the
// parser and result logic into the result register, so a byte is taken on
// every cycle unless a newline waits in the input register for the result.
// A newline byte waits in the input register while an earlier result has
// not been taken; other bytes pass freely while a result waits.
// Reset is synchronous and clears the parse state, counters, box and the
// scale register (back to 50); it takes effect on the next clock edge.
// ----------------------------------------------------------------------------
module plotter_command_line_parser #(
   parameter int COORD_BITS = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [7:0]                              req_char_in,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [1:0]                              rsp_action,
   output logic signed [plcp_pkg::TARGET_BITS-1:0] rsp_target_x,
   output logic signed [plcp_pkg::TARGET_BITS-1:0] rsp_target_y,
   output logic signed [plcp_pkg::FIELD_BITS-1:0]  rsp_box_min_x,
   output logic signed [plcp_pkg::FIELD_BITS-1:0]  rsp_box_max_x,
   output logic signed [plcp_pkg::FIELD_BITS-1:0]  rsp_box_min_y,
   output logic signed [plcp_pkg::FIELD_BITS-1:0]  rsp_box_max_y,
   output logic                                    rsp_box_valid,
   output logic [plcp_pkg::FIELD_BITS-1:0]         rsp_pen_up_count,
   output logic [plcp_pkg::FIELD_BITS-1:0]         rsp_pen_down_count,
   output logic [plcp_pkg::FIELD_BITS-1:0]         rsp_pen_select_count,
   output logic [plcp_pkg::FIELD_BITS-1:0]         rsp_line_count,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [plcp_pkg::SCALE_BITS-1:0]         csr_coord_scale
);
   import plcp_pkg::*;

   // The scale register. Writes are to be made only while the block is idle;
   // the user must keep to this, the block does not enforce it. The port is always ready.
   logic [SCALE_BITS-1:0] scale_ff;

   // Input register: one byte waiting to be consumed.
   logic       in_valid_ff;
   logic [7:0] in_char_ff;

   logic       out_free;
   logic       consume;
   event_type  ev;
   logic signed [COORD_BITS-1:0] point_x, point_y;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_valid) begin
         scale_ff <= csr_coord_scale;
      end
   end

   // The result register is free when empty or being emptied this cycle.
   // Only a newline needs it; every other byte is consumed at once.
   assign out_free  = !rsp_valid || rsp_ready;
   assign consume   = in_valid_ff && ((in_char_ff != CH_LF) || out_free);
   assign req_ready = !in_valid_ff || consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_char_ff <= req_char_in;
      end
   end

   plcp_parse #(
      .COORD_BITS(COORD_BITS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (consume),
      .char_in (in_char_ff),
      .ev      (ev),
      .point_x (point_x),
      .point_y (point_y)
   );

   plcp_result #(
      .COORD_BITS(COORD_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) u_result (
      .clock                (clock),
      .reset                (reset),
      .step                 (consume),
      .ev                   (ev),
      .point_x              (point_x),
      .point_y              (point_y),
      .scale                (scale_ff),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_action           (rsp_action),
      .rsp_target_x         (rsp_target_x),
      .rsp_target_y         (rsp_target_y),
      .rsp_box_min_x        (rsp_box_min_x),
      .rsp_box_max_x        (rsp_box_max_x),
      .rsp_box_min_y        (rsp_box_min_y),
      .rsp_box_max_y        (rsp_box_max_y),
      .rsp_box_valid        (rsp_box_valid),
      .rsp_pen_up_count     (rsp_pen_up_count),
      .rsp_pen_down_count   (rsp_pen_down_count),
      .rsp_pen_select_count (rsp_pen_select_count),
      .rsp_line_count       (rsp_line_count)
   );

`ifndef ASSERT_OFF
   // A held newline must never be consumed while the result register is full.
   a_newline_waits: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && (in_char_ff == CH_LF) && rsp_valid && !rsp_ready) |-> !consume)
      else $error("newline consumed while result register occupied");

   // Consuming a newline always yields a result beat in the next cycle.
   a_newline_result: assert property (@(posedge clock) disable iff (reset)
      (consume && (in_char_ff == CH_LF)) |=> rsp_valid)
      else $error("newline did not produce a result");

   // A valid bounding box is never inverted.
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_box_valid) |->
         ((rsp_box_min_x <= rsp_box_max_x) && (rsp_box_min_y <= rsp_box_max_y)))
      else $error("bounding box inverted");

   // Results without a point carry zero targets.
   a_zero_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_action == ACT_NONE) || (rsp_action == ACT_HOME))) |->
         ((rsp_target_x == '0) && (rsp_target_y == '0)))
      else $error("nonzero target without a point");

   // Each result counts at least one line.
   a_line_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_count != '0))
      else $error("result with zero line count");
`endif

endmodule
